### src/disparity_to_point_cloud_core_macros.svh
// assertion macros for the disparity to point cloud core
// used by the checker; no other dependencies
`ifndef DISPARITY_TO_POINT_CLOUD_CORE_MACROS_SVH
`define DISPARITY_TO_POINT_CLOUD_CORE_MACROS_SVH

// clocked assertion, off during reset
`define DTPC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define DTPC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/dtpc_pkg.sv
// shared types, constants and helpers for the disparity to point cloud core
// no dependencies
package dtpc_pkg;

  localparam int COORD_LIMIT = 4096;
  localparam int DIV_STEPS = 32;
  localparam int ADDR_W = 5;
  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_FOCAL       = 3'd1,
    REG_PRINC_X     = 3'd2,
    REG_PRINC_Y     = 3'd3,
    REG_LIMIT_X     = 3'd4,
    REG_LIMIT_Y     = 3'd5,
    REG_LIMIT_Z     = 3'd6,
    REG_PICK        = 3'd7
  } dtpc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ZDIV, ST_XSTART, ST_XDIV, ST_YDIV, ST_JUDGE, ST_EMIT
  } dtpc_state_t;

  typedef enum logic [1:0] {
    DSEL_Z, DSEL_X, DSEL_Y
  } dtpc_dsel_t;

  typedef struct packed {
    logic [31:0] depth_scale;
    logic [30:0] focal_length;
    logic [27:0] principal_x;
    logic [27:0] principal_y;
    logic [30:0] limit_x;
    logic [30:0] limit_y;
    logic [30:0] limit_z;
    logic [15:0] pick_period;
  } dtpc_cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    dtpc_dsel_t div_sel;
    logic       take_z;
    logic       take_x;
    logic       take_y;
    logic       judge;
    logic       emit;
  } dtpc_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic div_done;
    logic keep;
    logic out_free;
  } dtpc_stat_t;

  function automatic logic [30:0] sat31(input logic [63:0] q);
    sat31 = (q[63:31] != '0) ? SAT31 : q[30:0];
  endfunction

endpackage

### src/dtpc_if.sv
// pixel and point channel interfaces
// depends on nothing
interface dtpc_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] disparity_raw;
  logic [11:0]        pixel_column;
  logic [11:0]        pixel_row;
  logic               frame_start;
  modport source(output valid, disparity_raw, pixel_column, pixel_row, frame_start,
                 input ready);
  modport sink(input valid, disparity_raw, pixel_column, pixel_row, frame_start,
               output ready);
endinterface

interface dtpc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [30:0]        point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

### src/dtpc_div.sv
// shared restoring divider, two quotient bits a cycle, 64 by 31 bits
// depends on dtpc_pkg
module dtpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [63:0] q;
  logic [30:0] d;
  logic        nz;
  logic [32:0] t1, t2, dd;
  logic        ge1, ge2;
  logic [31:0] r1, r2;

  always_comb begin
    dd  = {2'b00, d};
    t1  = {rem, q[63]};
    ge1 = t1 >= dd;
    r1  = ge1 ? 32'(t1 - dd) : t1[31:0];
    t2  = {r1, q[62]};
    ge2 = t2 >= dd;
    r2  = ge2 ? 32'(t2 - dd) : t2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(dtpc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
      nz  <= (num == '0);
    end else if (busy) begin
      rem <= r2;
      q   <= {q[61:0], ge1, ge2};
    end
  end

  assign quo = nz ? 64'd0 : q;
endmodule

### src/dtpc_dp.sv
// datapath: pixel registers, divider operands, limit check, pick counter, output beat
// depends on dtpc_pkg, dtpc_div
module dtpc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  dtpc_pkg::dtpc_cfg_t  cfg,
  input  dtpc_pkg::dtpc_cmd_t  cmd,
  output dtpc_pkg::dtpc_stat_t stat,
  input  logic signed [15:0]   disparity_raw,
  input  logic [11:0]          pixel_column,
  input  logic [11:0]          pixel_row,
  input  logic                 frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   point_x,
  output logic signed [31:0]   point_y,
  output logic [30:0]          point_z
);
  logic [11:0] col, row;
  logic [30:0] z, xm, ym;
  logic [15:0] valid_count;
  logic [27:0] posx, posy, magx, magy;
  logic        xneg, yneg;
  logic [63:0] num;
  logic [30:0] den;
  logic [63:0] quo;
  logic        div_done;
  logic [15:0] cnt_inc, period;
  logic        pass, hit;

  always_comb begin
    posx = {col, 16'd0};
    posy = {row, 16'd0};
    xneg = posx < cfg.principal_x;
    yneg = posy < cfg.principal_y;
    magx = xneg ? cfg.principal_x - posx : posx - cfg.principal_x;
    magy = yneg ? cfg.principal_y - posy : posy - cfg.principal_y;
    case (cmd.div_sel)
      dtpc_pkg::DSEL_Z: begin
        num = {28'd0, cfg.depth_scale, 4'd0};
        den = {16'd0, disparity_raw[14:0]};
      end
      dtpc_pkg::DSEL_X: begin
        num = {36'd0, magx} * {33'd0, z};
        den = cfg.focal_length;
      end
      dtpc_pkg::DSEL_Y: begin
        num = {36'd0, magy} * {33'd0, z};
        den = cfg.focal_length;
      end
      default: begin
        num = '0;
        den = cfg.focal_length;
      end
    endcase
  end

  dtpc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(den),
    .done(div_done), .quo(quo)
  );

  always_comb begin
    period  = (cfg.pick_period == '0) ? 16'd1 : cfg.pick_period;
    cnt_inc = valid_count + 16'd1;
    hit     = cnt_inc >= period;
    pass    = (xm <= cfg.limit_x) && (ym <= cfg.limit_y) && (z <= cfg.limit_z);
    stat.keep     = pass && hit;
    stat.div_done = div_done;
    stat.in_ok    = !disparity_raw[15] && (disparity_raw != '0)
                    && (int'(pixel_column) < dtpc_pkg::COORD_LIMIT)
                    && (int'(pixel_row) < dtpc_pkg::COORD_LIMIT);
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col <= pixel_column;
      row <= pixel_row;
    end
    if (cmd.take_z) z  <= dtpc_pkg::sat31(quo);
    if (cmd.take_x) xm <= dtpc_pkg::sat31(quo);
    if (cmd.take_y) ym <= dtpc_pkg::sat31(quo);
    if (cmd.emit) begin
      point_x <= xneg ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
      point_y <= yneg ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
      point_z <= z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load && frame_start) begin
        valid_count <= '0;
      end else if (cmd.judge && pass) begin
        valid_count <= hit ? 16'd0 : cnt_inc;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

### src/dtpc_ctrl.sv
// controller state machine sequencing the three divisions of one pixel
// depends on dtpc_pkg
module dtpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtpc_pkg::dtpc_stat_t stat,
  output dtpc_pkg::dtpc_cmd_t  cmd
);
  dtpc_pkg::dtpc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = dtpc_pkg::DSEL_Z;
    in_ready   = 1'b0;
    case (state)
      dtpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_ok) begin
            cmd.div_start = 1'b1;
            state_next    = dtpc_pkg::ST_ZDIV;
          end
        end
      end
      dtpc_pkg::ST_ZDIV: begin
        if (stat.div_done) begin
          cmd.take_z = 1'b1;
          state_next = dtpc_pkg::ST_XSTART;
        end
      end
      dtpc_pkg::ST_XSTART: begin
        cmd.div_sel   = dtpc_pkg::DSEL_X;
        cmd.div_start = 1'b1;
        state_next    = dtpc_pkg::ST_XDIV;
      end
      dtpc_pkg::ST_XDIV: begin
        cmd.div_sel = dtpc_pkg::DSEL_Y;
        if (stat.div_done) begin
          cmd.take_x    = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = dtpc_pkg::ST_YDIV;
        end
      end
      dtpc_pkg::ST_YDIV: begin
        if (stat.div_done) begin
          cmd.take_y = 1'b1;
          state_next = dtpc_pkg::ST_JUDGE;
        end
      end
      dtpc_pkg::ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = stat.keep ? dtpc_pkg::ST_EMIT : dtpc_pkg::ST_IDLE;
      end
      dtpc_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = dtpc_pkg::ST_IDLE;
        end
      end
      default: state_next = dtpc_pkg::ST_IDLE;
    endcase
  end
endmodule

### src/disparity_to_point_cloud_core.sv
// top level: register file, controller and datapath of the point reprojection
// depends on dtpc_pkg, dtpc_if, dtpc_ctrl, dtpc_dp
//
//   channel   dir  beat
//   pixels    in   disparity_raw, pixel_column, pixel_row, frame_start
//   points    out  point_x, point_y, point_z
//   apb       in   register writes and reads, no wait states
//
// one pixel at a time; a pixel without disparity or off the grid is dropped from idle
// a projected pixel takes 3 divisions on the shared divider and a judge step,
// then may wait for the output register to drain
// synchronous reset clears the controller, pick counter and output valid
// a held output beat stalls only the next emitted point
module disparity_to_point_cloud_core (
  input  logic                            clk,
  input  logic                            rst,
  dtpc_pixel_if.sink                      pixels,
  dtpc_point_if.source                    points,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtpc_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  dtpc_pkg::dtpc_cfg_t  cfg;
  dtpc_pkg::dtpc_cmd_t  cmd;
  dtpc_pkg::dtpc_stat_t stat;
  dtpc_pkg::dtpc_reg_e  ridx;

  assign pready = 1'b1;
  assign ridx   = dtpc_pkg::dtpc_reg_e'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_scale  <= 32'd65536;
      cfg.focal_length <= 31'd65536;
      cfg.principal_x  <= '0;
      cfg.principal_y  <= '0;
      cfg.limit_x      <= 31'd1310720;
      cfg.limit_y      <= 31'd1310720;
      cfg.limit_z      <= 31'd2621440;
      cfg.pick_period  <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        dtpc_pkg::REG_DEPTH_SCALE: cfg.depth_scale  <= pwdata;
        dtpc_pkg::REG_FOCAL:       cfg.focal_length <= pwdata[30:0];
        dtpc_pkg::REG_PRINC_X:     cfg.principal_x  <= pwdata[27:0];
        dtpc_pkg::REG_PRINC_Y:     cfg.principal_y  <= pwdata[27:0];
        dtpc_pkg::REG_LIMIT_X:     cfg.limit_x      <= pwdata[30:0];
        dtpc_pkg::REG_LIMIT_Y:     cfg.limit_y      <= pwdata[30:0];
        dtpc_pkg::REG_LIMIT_Z:     cfg.limit_z      <= pwdata[30:0];
        dtpc_pkg::REG_PICK:        cfg.pick_period  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      dtpc_pkg::REG_DEPTH_SCALE: prdata = cfg.depth_scale;
      dtpc_pkg::REG_FOCAL:       prdata = {1'b0, cfg.focal_length};
      dtpc_pkg::REG_PRINC_X:     prdata = {4'd0, cfg.principal_x};
      dtpc_pkg::REG_PRINC_Y:     prdata = {4'd0, cfg.principal_y};
      dtpc_pkg::REG_LIMIT_X:     prdata = {1'b0, cfg.limit_x};
      dtpc_pkg::REG_LIMIT_Y:     prdata = {1'b0, cfg.limit_y};
      dtpc_pkg::REG_LIMIT_Z:     prdata = {1'b0, cfg.limit_z};
      dtpc_pkg::REG_PICK:        prdata = {16'd0, cfg.pick_period};
      default:                   prdata = '0;
    endcase
  end

  dtpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(pixels.valid), .in_ready(pixels.ready),
    .stat(stat), .cmd(cmd)
  );

  dtpc_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .stat(stat),
    .disparity_raw(pixels.disparity_raw), .pixel_column(pixels.pixel_column),
    .pixel_row(pixels.pixel_row), .frame_start(pixels.frame_start),
    .out_valid(points.valid), .out_ready(points.ready),
    .point_x(points.point_x), .point_y(points.point_y), .point_z(points.point_z)
  );
endmodule

### src/dtpc_checker.sv
// port-level checks of the disparity to point cloud core, bound to the top level
// depends on disparity_to_point_cloud_core_macros.svh
`include "disparity_to_point_cloud_core_macros.svh"

module dtpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] point_z,
  input logic        pready
);
  `DTPC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(point_z), "point beat dropped or changed while stalled")
  `DTPC_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !out_valid || !$rose(out_valid), "point emitted right after a pixel accept")
  `DTPC_ASSERT(a_emit_while_busy, clk, rst, $rose(out_valid) |-> $past(!in_ready), "point emitted while the block was idle")
  `DTPC_ASSERT_ALWAYS(a_pready, clk, pready, "configuration port inserted a wait state")
endmodule

bind disparity_to_point_cloud_core dtpc_checker u_dtpc_checker (
  .clk(clk), .rst(rst),
  .in_valid(pixels.valid), .in_ready(pixels.ready),
  .out_valid(points.valid), .out_ready(points.ready),
  .point_z(points.point_z), .pready(pready)
);

### dv/disparity_to_point_cloud_core_tb.sv
// self-checking testbench for disparity_to_point_cloud_core: directed pixel table, then
// random pixels under several register settings, checked against an internal projection
// depends on dtpc_pkg, dtpc_if and the core rtl
module disparity_to_point_cloud_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtpc_pkg::*;

  localparam logic [63:0] SAT = 64'h7FFF_FFFF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        z;
  } point_t;

  typedef struct {
    logic signed [15:0] raw;
    logic [11:0]        col;
    logic [11:0]        row;
    bit                 fs;
    bit                 typed;
    bit                 emits;
    point_t             pt;
  } pixel_row_t;

  logic clk = 0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  dtpc_pixel_if pixels();
  dtpc_point_if points();

  disparity_to_point_cloud_core dut (
    .clk(clk), .rst(rst), .pixels(pixels), .points(points),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [31:0] depth_scale;
  logic [30:0] focal_length, limit_x, limit_y, limit_z;
  logic [27:0] principal_x, principal_y;
  logic [15:0] pick_period, valid_count;

  point_t pending_points[$];
  int errors = 0;
  int pixels_sent = 0;
  int points_seen = 0;
  int quiet_cycles = 0;
  bit calm = 0;
  int ready_gap = 0;

  function automatic logic [30:0] lateral_mag(input logic [11:0] pix, input logic [27:0] c,
                                              input logic [30:0] z, output bit neg);
    logic [63:0] pos, mag, prod, q;
    pos = {52'd0, pix} << 16;
    if (pos >= {36'd0, c}) begin
      mag = pos - c;
      neg = 0;
    end else begin
      mag = c - pos;
      neg = 1;
    end
    prod = mag * z;
    if (focal_length != 0) q = prod / focal_length;
    else q = (prod != 0) ? SAT : 64'd0;
    return (q > SAT) ? SAT[30:0] : q[30:0];
  endfunction

  function automatic bit project_pixel(input logic signed [15:0] raw, input logic [11:0] col,
                                       input logic [11:0] row, input bit fs, output point_t p);
    logic [63:0] zq;
    logic [30:0] z, xm, ym;
    bit xn, yn;
    logic [15:0] period;
    if (fs) valid_count = 0;
    if (raw <= 0) return 0;
    zq = ({32'd0, depth_scale} << 4) / {48'd0, raw};
    z = (zq > SAT) ? SAT[30:0] : zq[30:0];
    xm = lateral_mag(col, principal_x, z, xn);
    ym = lateral_mag(row, principal_y, z, yn);
    if (xm > limit_x || ym > limit_y || z > limit_z) return 0;
    period = (pick_period == 0) ? 16'd1 : pick_period;
    valid_count = valid_count + 16'd1;
    if (valid_count < period) return 0;
    valid_count = 0;
    p.x = xn ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
    p.y = yn ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
    p.z = z;
    return 1;
  endfunction

  task automatic write_reg(input dtpc_reg_e r, input logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    case (r)
      REG_DEPTH_SCALE: depth_scale = v;
      REG_FOCAL:       focal_length = v[30:0];
      REG_PRINC_X:     principal_x = v[27:0];
      REG_PRINC_Y:     principal_y = v[27:0];
      REG_LIMIT_X:     limit_x = v[30:0];
      REG_LIMIT_Y:     limit_y = v[30:0];
      REG_LIMIT_Z:     limit_z = v[30:0];
      REG_PICK:        pick_period = v[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_row_t r);
    point_t p;
    bit e;
    if (!calm && $urandom_range(0, 3) == 0) begin
      pixels.valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pixels.valid <= 1;
    pixels.disparity_raw <= r.raw;
    pixels.pixel_column <= r.col;
    pixels.pixel_row <= r.row;
    pixels.frame_start <= r.fs;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    e = project_pixel(r.raw, r.col, r.row, r.fs, p);
    if (r.typed) begin
      e = r.emits;
      p = r.pt;
    end
    if (e) pending_points.push_back(p);
    pixels_sent++;
  endtask

  task automatic random_pixels(input int n);
    pixel_row_t r;
    repeat (n) begin
      r = '{default: 0};
      case ($urandom_range(0, 9))
        0: r.raw = $urandom_range(0, 65535);
        1: r.raw = $urandom_range(1, 64);
        default: r.raw = $urandom_range(1, 32767);
      endcase
      r.col = $urandom_range(0, 4095);
      r.row = $urandom_range(0, 4095);
      r.fs = ($urandom_range(0, 15) == 0);
      send_pixel(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      points.ready <= 0;
    end else if (calm) begin
      points.ready <= 1;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      points.ready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      ready_gap <= $urandom_range(0, 14);
      points.ready <= 0;
    end else begin
      points.ready <= 1;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && points.valid && points.ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t unexpected point x=%0d y=%0d z=%0d", $time,
                 points.point_x, points.point_y, points.point_z);
      end else begin
        want = pending_points.pop_front();
        if (points.point_x !== want.x) begin
          errors++;
          $display("%0t point_x expected %0d actual %0d", $time, want.x, points.point_x);
        end
        if (points.point_y !== want.y) begin
          errors++;
          $display("%0t point_y expected %0d actual %0d", $time, want.y, points.point_y);
        end
        if (points.point_z !== want.z) begin
          errors++;
          $display("%0t point_z expected %0d actual %0d", $time, want.z, points.point_z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixels.valid && pixels.ready) || (points.valid && points.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("disparity_to_point_cloud_core_tb: errors");
        $finish;
      end
    end
  end

  pixel_row_t table_rows[] = '{
    '{16'sd16, 12'd1, 12'd0, 1, 1, 1, '{32'sd65536, 32'sd0, 31'd65536}},
    '{16'sd0, 12'd5, 12'd5, 0, 1, 0, '{0, 0, 0}},
    '{-16'sd1, 12'd5, 12'd5, 0, 1, 0, '{0, 0, 0}},
    '{-16'sd32768, 12'd0, 12'd0, 0, 1, 0, '{0, 0, 0}},
    '{16'sd32767, 12'd4095, 12'd4095, 0, 1, 1, '{32'sd131040, 32'sd131040, 31'd32}},
    '{16'sd1, 12'd0, 12'd0, 0, 1, 1, '{32'sd0, 32'sd0, 31'd1048576}},
    '{16'sd16, 12'd4095, 12'd0, 0, 1, 0, '{0, 0, 0}},
    '{16'sd8, 12'd3, 12'd7, 1, 0, 0, '{0, 0, 0}},
    '{16'sd100, 12'd2048, 12'd17, 0, 0, 0, '{0, 0, 0}},
    '{16'sd2, 12'd9, 12'd4, 0, 0, 0, '{0, 0, 0}},
    '{16'sd32767, 12'd0, 12'd4095, 1, 0, 0, '{0, 0, 0}},
    '{16'sd4096, 12'd1365, 12'd2730, 0, 0, 0, '{0, 0, 0}}
  };

  initial begin
    rst = 1;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    pixels.valid <= 0;
    pixels.disparity_raw <= '0;
    pixels.pixel_column <= '0;
    pixels.pixel_row <= '0;
    pixels.frame_start <= 0;
    depth_scale = 32'd65536;
    focal_length = 31'd65536;
    principal_x = 0;
    principal_y = 0;
    limit_x = 31'd1310720;
    limit_y = 31'd1310720;
    limit_z = 31'd2621440;
    pick_period = 16'd1;
    valid_count = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (table_rows[i]) send_pixel(table_rows[i]);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_DEPTH_SCALE, $urandom);
    write_reg(REG_FOCAL, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_PRINC_X, $urandom_range(0, 32'h0FFF_FFFF));
    write_reg(REG_PRINC_Y, $urandom_range(0, 32'h0FFF_FFFF));
    write_reg(REG_LIMIT_X, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Y, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Z, 32'h7FFF_FFFF);
    write_reg(REG_PICK, $urandom_range(1, 4));
    random_pixels(90);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_DEPTH_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_FOCAL, 1);
    write_reg(REG_PRINC_X, 0);
    write_reg(REG_PRINC_Y, 32'h0FFF_FFFF);
    write_reg(REG_PICK, 1);
    random_pixels(70);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_DEPTH_SCALE, 1);
    write_reg(REG_FOCAL, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_X, 0);
    write_reg(REG_LIMIT_Y, 0);
    write_reg(REG_LIMIT_Z, 0);
    write_reg(REG_PICK, 0);
    random_pixels(60);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_DEPTH_SCALE, $urandom);
    write_reg(REG_FOCAL, 0);
    write_reg(REG_PRINC_X, $urandom_range(0, 32'h0FFF_FFFF));
    write_reg(REG_LIMIT_X, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Y, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Z, 32'h7FFF_FFFF);
    write_reg(REG_PICK, 3);
    random_pixels(70);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_DEPTH_SCALE, 32'h0010_0000);
    write_reg(REG_FOCAL, 32'h0010_0000);
    write_reg(REG_PRINC_X, 32'h0800_0000);
    write_reg(REG_PRINC_Y, 32'h0600_0000);
    write_reg(REG_LIMIT_X, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_LIMIT_Y, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_LIMIT_Z, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_PICK, 9);
    random_pixels(70);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_PICK, 2);
    write_reg(REG_LIMIT_X, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Y, 32'h7FFF_FFFF);
    write_reg(REG_LIMIT_Z, 32'h7FFF_FFFF);
    random_pixels(60);
    pixels.valid <= 0;
    wait_idle();

    write_reg(REG_PICK, 16'hFFFF);
    random_pixels(30);
    pixels.valid <= 0;
    wait_idle();

    calm = 1;
    write_reg(REG_DEPTH_SCALE, $urandom);
    write_reg(REG_FOCAL, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(REG_PICK, 1);
    random_pixels(90);
    pixels.valid <= 0;
    wait_idle();

    $display("covered %0d pixels and %0d points over nine register settings", pixels_sent,
             points_seen);
    if (errors == 0) begin
      $display("disparity_to_point_cloud_core_tb: clean");
    end else begin
      $display("disparity_to_point_cloud_core_tb: errors");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/dtpc_pkg.sv
src/dtpc_if.sv
src/dtpc_div.sv
src/dtpc_dp.sv
src/dtpc_ctrl.sv
src/disparity_to_point_cloud_core.sv
src/dtpc_checker.sv
dv/disparity_to_point_cloud_core_tb.sv
